// ----- rtl/credit_admission_queue_top_assert.svh -----
// assertion macros for the credit admission queue checker
`ifndef CREDIT_ADMISSION_QUEUE_TOP_ASSERT_SVH
`define CREDIT_ADMISSION_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cdq_pkg.sv -----
`default_nettype none

package cdq_pkg;

    // fixed field widths
    localparam int TAG_W    = 32;
    localparam int FREE_W   = 5;
    localparam int QCNT_W   = 7;
    localparam int LIMIT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // output stream packing
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - TAG_W - FREE_W - QCNT_W;

    // defaults
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 32;
    localparam int MAX_SLOTS_DEF   = 16;

    localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 7'd32;

    // register indexes
    localparam logic REG_QUEUE_LIMIT = 1'b0;

    // input modes
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_FREED  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE_FREE  = 2'd3;

    // queue control from the decision logic
    typedef struct packed {
        logic push;
        logic pop;
    } cdq_qctl_t;

endpackage

`default_nettype wire

// ----- rtl/cdq_queue.sv -----
`default_nettype none

module cdq_queue
    import cdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DATA_BITS   = TAG_W,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cdq_qctl_t            qctl,
    input  wire logic [DATA_BITS-1:0] push_data,
    output logic      [DATA_BITS-1:0] head_data,
    output logic      [CNT_W-1:0]     count,
    output logic      [CNT_W-1:0]     count_next
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [DATA_BITS-1:0] store_mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 byp_reg;
    logic                 byp_next;
    logic [DATA_BITS-1:0] byp_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (qctl.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (qctl.push)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    // an entry written where the next head lies is forwarded
    assign byp_next  = qctl.push && (tail_reg == head_next);
    assign head_data = byp_reg ? byp_data_reg : rd_data_reg;
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            byp_reg   <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (qctl.push)
        begin
            store_mem[tail_reg] <= push_data;
        end
        rd_data_reg  <= store_mem[head_next];
        byp_data_reg <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/credit_admission_queue_top.sv -----
// datapath: an accepted request is held in the input register, its result in the result register
// throughput: one request per cycle while the result stream is not stalled, set by the
// single decision stage between the input register and the result register
// reset: asynchronous, clears credits, queue pointers and handshake state,
// queue_limit returns to 32; queue entries stay unwritten
`default_nettype none

module credit_admission_queue_top
    import cdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    // request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TAG_W-1:0]      s_tdata,   // [31:0] job_tag
    input  wire logic                  s_tuser,   // [0] mode
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // [31:0] dispatch_tag, [36:32] free_slots,
                                                  // [43:37] queued_count, [47:44] zero
    output logic      [STATUS_W-1:0]   m_tuser    // [1:0] status
);

    localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int CRD_W      = $clog2(MAX_SLOTS + 1);

    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(QUEUE_DEPTH);
    localparam logic [CRD_W-1:0] CRD_MAX   = CRD_W'(MAX_SLOTS);

    // config register
    logic [LIMIT_W-1:0]    queue_limit_reg;
    logic                  cfg_wr;

    // input register
    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic [STORE_BITS-1:0] in_tag_reg;
    logic                  in_load;
    logic                  adv;

    // state
    logic [CRD_W-1:0]      credits_reg;
    logic [CRD_W-1:0]      credits_next;
    logic [CRD_W-1:0]      credits_inc;

    // queue
    cdq_qctl_t             qctl;
    logic [STORE_BITS-1:0] head_data;
    logic [CNT_W-1:0]      qcount;
    logic [CNT_W-1:0]      qcount_next;
    logic [LIM_W-1:0]      limit_eff;

    // result register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [TAG_W-1:0]      dtag_reg;
    logic [TAG_W-1:0]      dtag_next;
    logic [FREE_W-1:0]     free_reg;
    logic [QCNT_W-1:0]     qcnt_reg;

    // config access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_LIMIT);
    assign prdata = (paddr[2] == REG_QUEUE_LIMIT) ? DATA_W'(queue_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= QUEUE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            queue_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // handshake
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_mode_reg <= s_tuser;
            in_tag_reg  <= s_tdata[STORE_BITS-1:0];
        end
    end

    // decision
    assign limit_eff   = (LIM_W'(queue_limit_reg) > DEPTH_LIM) ? DEPTH_LIM
                                                               : LIM_W'(queue_limit_reg);
    assign credits_inc = (credits_reg < CRD_MAX) ? credits_reg + 1'b1 : credits_reg;

    always_comb
    begin
        qctl         = '0;
        credits_next = credits_reg;
        status_next  = ST_REJECTED;
        dtag_next    = '0;
        case (in_mode_reg)
            MODE_ARRIVE:
            begin
                if (credits_reg != '0)
                begin
                    credits_next = credits_reg - 1'b1;
                    status_next  = ST_DISPATCHED;
                    dtag_next    = TAG_W'(in_tag_reg);
                end
                else if (LIM_W'(qcount) < limit_eff)
                begin
                    qctl.push   = adv;
                    status_next = ST_QUEUED;
                end
                else
                begin
                    status_next = ST_REJECTED;
                end
            end
            MODE_FREED:
            begin
                if (qcount != '0)
                begin
                    // the freed slot goes straight to the oldest waiting job
                    qctl.pop     = adv;
                    credits_next = credits_inc - 1'b1;
                    status_next  = ST_DISPATCHED;
                    dtag_next    = TAG_W'(head_data);
                end
                else
                begin
                    credits_next = credits_inc;
                    status_next  = ST_IDLE_FREE;
                end
            end
            default:
            begin
                status_next = ST_REJECTED;
            end
        endcase
    end

    cdq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_BITS   (STORE_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .qctl       (qctl),
        .push_data  (in_tag_reg),
        .head_data  (head_data),
        .count      (qcount),
        .count_next (qcount_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credits_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                credits_reg <= credits_next;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            dtag_reg   <= dtag_next;
            free_reg   <= FREE_W'(credits_next);
            qcnt_reg   <= QCNT_W'(qcount_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, qcnt_reg, free_reg, dtag_reg};

endmodule

`default_nettype wire

// ----- rtl/cdq_checker.sv -----
`default_nettype none

`include "credit_admission_queue_top_assert.svh"

module cdq_checker
    import cdq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [STATUS_W-1:0]   m_tuser
);

    // a stalled result holds
    `CDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // no tag leaks out unless a job is dispatched
    `CDQ_ASSERT_NOW(a_tag_zero, m_tvalid && (m_tuser != ST_DISPATCHED), m_tdata[TAG_W-1:0] == '0, "dispatch tag set without dispatch")

    // queueing or rejecting only happens with no credit left
    `CDQ_ASSERT_NOW(a_no_credit, m_tvalid && ((m_tuser == ST_QUEUED) || (m_tuser == ST_REJECTED)), m_tdata[TAG_W+FREE_W-1:TAG_W] == '0, "arrival held back while credits free")

    // a freed slot with nothing sent means the queue is empty
    `CDQ_ASSERT_NOW(a_idle_empty, m_tvalid && (m_tuser == ST_IDLE_FREE), m_tdata[TAG_W+FREE_W+QCNT_W-1:TAG_W+FREE_W] == '0, "freed slot unused with jobs waiting")

endmodule

bind credit_admission_queue_top cdq_checker u_cdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import cdq_pkg::*;

    typedef struct {
        logic             mode;
        logic [TAG_W-1:0] tag;
    } job_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [FREE_W-1:0]   free;
        logic [QCNT_W-1:0]   qcnt;
    } admit_result_t;

    localparam int JOB_SLOTS = 1024;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TAG_W-1:0]      s_tdata  = '0;   // [31:0] job_tag
    logic                  s_tuser  = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [31:0] dispatch_tag, [36:32] free_slots,
                                            // [43:37] queued_count, [47:44] zero
    logic [STATUS_W-1:0]   m_tuser;         // [1:0] status

    credit_admission_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // admission state mirror
    logic [TAG_W-1:0]   waiting_tags [QUEUE_DEPTH_DEF];
    logic [5:0]         oldest_slot    = '0;
    logic [5:0]         free_entry     = '0;
    logic [QCNT_W-1:0]  waiting_jobs   = '0;
    logic [FREE_W-1:0]  slot_credits   = '0;
    logic [LIMIT_W-1:0] waiting_limit  = QUEUE_LIMIT_RST;

    // ring buffers of pending requests and expected results
    job_req_t      pending_jobs [JOB_SLOTS];
    admit_result_t expected_outcomes [JOB_SLOTS];
    int unsigned   job_wr = 0;
    int unsigned   job_rd = 0;
    int unsigned   exp_wr = 0;
    int unsigned   exp_rd = 0;
    job_req_t      next_req;
    admit_result_t oldest_outcome;

    int unsigned issued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int          src_gap        = 0;
    int          snk_gap        = 0;
    int          src_idle_pct   = 0;
    int          snk_idle_pct   = 0;

    function automatic int pick_gap(input int pct);
        int roll;
        if ($urandom_range(99) >= pct)
            return 0;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 93)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic admit_job(input logic mode, input logic [TAG_W-1:0] tag);
        admit_result_t res;
        int unsigned   eff_limit;
        res.status = ST_IDLE_FREE;
        res.tag    = '0;
        eff_limit  = (waiting_limit > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : waiting_limit;
        if (mode == MODE_ARRIVE)
        begin
            if (slot_credits != 0)
            begin
                slot_credits = slot_credits - 1'b1;
                res.status   = ST_DISPATCHED;
                res.tag      = tag;
            end
            else if (waiting_jobs < eff_limit)
            begin
                waiting_tags[free_entry] = tag;
                free_entry   = free_entry + 1'b1;
                waiting_jobs = waiting_jobs + 1'b1;
                res.status   = ST_QUEUED;
            end
            else
            begin
                res.status = ST_REJECTED;
            end
        end
        else
        begin
            // credit saturates before the waiting job takes it back
            if (slot_credits < MAX_SLOTS_DEF)
                slot_credits = slot_credits + 1'b1;
            if (waiting_jobs != 0)
            begin
                res.tag      = waiting_tags[oldest_slot];
                oldest_slot  = oldest_slot + 1'b1;
                waiting_jobs = waiting_jobs - 1'b1;
                if (slot_credits != 0)
                    slot_credits = slot_credits - 1'b1;
                res.status = ST_DISPATCHED;
            end
        end
        res.free = slot_credits;
        res.qcnt = waiting_jobs;
        expected_outcomes[exp_wr % JOB_SLOTS] = res;
        exp_wr++;
    endtask

    // request source
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                admit_job(s_tuser, s_tdata);
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (job_rd != job_wr)
                begin
                    next_req = pending_jobs[job_rd % JOB_SLOTS];
                    job_rd++;
                    issued_count++;
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.mode;
                    s_tdata  <= next_req.tag;
                    src_gap  = pick_gap(src_idle_pct);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_rd == exp_wr)
                begin
                    $display("%0t: result with none expected, status %0d tdata %h",
                             $time, m_tuser, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    oldest_outcome = expected_outcomes[exp_rd % JOB_SLOTS];
                    exp_rd++;
                    if (m_tuser !== oldest_outcome.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, oldest_outcome.status, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[31:0] !== oldest_outcome.tag)
                    begin
                        $display("%0t: dispatch_tag mismatch, expected %h, actual %h",
                                 $time, oldest_outcome.tag, m_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[36:32] !== oldest_outcome.free)
                    begin
                        $display("%0t: free_slots mismatch, expected %0d, actual %0d",
                                 $time, oldest_outcome.free, m_tdata[36:32]);
                        mismatch_count++;
                    end
                    if (m_tdata[43:37] !== oldest_outcome.qcnt)
                    begin
                        $display("%0t: queued_count mismatch, expected %0d, actual %0d",
                                 $time, oldest_outcome.qcnt, m_tdata[43:37]);
                        mismatch_count++;
                    end
                    if (m_tdata[47:44] !== 4'd0)
                    begin
                        $display("%0t: tdata pad mismatch, expected 0, actual %h",
                                 $time, m_tdata[47:44]);
                        mismatch_count++;
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                snk_gap  = pick_gap(snk_idle_pct);
            end
        end
    end

    task automatic write_queue_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_QUEUE_LIMIT, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        waiting_limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_request(input logic mode, input logic [TAG_W-1:0] tag);
        job_req_t req;
        req.mode = mode;
        req.tag  = tag;
        pending_jobs[job_wr % JOB_SLOTS] = req;
        job_wr++;
    endtask

    function automatic logic [TAG_W-1:0] random_tag();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (job_rd != job_wr || issued_count != accepted_count || exp_rd != exp_wr)
            @(negedge clk);
        // leave margin past the last result before touching the register
        repeat (4) @(posedge clk);
    endtask

    task automatic run_load(input logic [LIMIT_W-1:0] limit, input int count,
                            input int arrive_pct, input int src_pct, input int snk_pct);
        write_queue_limit(limit);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < arrive_pct)
                add_request(MODE_ARRIVE, random_tag());
            else
                add_request(MODE_FREED, random_tag());
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: queue two extreme tags, drain them, then saturate credits
        src_idle_pct = 30;
        snk_idle_pct = 30;
        add_request(MODE_ARRIVE, 32'h0000_0000);
        add_request(MODE_ARRIVE, 32'hFFFF_FFFF);
        add_request(MODE_FREED,  32'h1234_5678);
        add_request(MODE_FREED,  32'h0);
        add_request(MODE_FREED,  32'hFFFF_FFFF);
        add_request(MODE_ARRIVE, 32'hA5A5_A5A5);
        repeat (17)
            add_request(MODE_FREED, 32'h5A5A_5A5A);
        add_request(MODE_ARRIVE, 32'h8000_0001);
        add_request(MODE_ARRIVE, 32'h7FFF_FFFE);
        wait_drained();

        // random load across limit settings, with varying idle profiles
        run_load(7'd0,   70, 80,  0,  0);
        run_load(7'd127, 150, 85, 40, 40);
        run_load(7'd64,  80, 25,  0, 50);
        run_load(7'd1,   60, 60, 50,  0);
        run_load(7'($urandom_range(2, 63)), 100, 55, 30, 30);
        run_load(7'd5,   100, 65,  0,  0);
        run_load(7'($urandom_range(0, 127)), 90, 50, 60, 60);

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** credit_admission_queue_top: PASSED **");
        else
            $display("** credit_admission_queue_top: FAILED **");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("** credit_admission_queue_top: FAILED **");
        $finish;
    end

endmodule
